// File: rtl/core/shs_pkg.sv
package shs_pkg;

	typedef logic [31:0] word_t;

	// one input request: a message byte and/or the end marker
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} shs_msg_t;

	// one output request: a digest word
	typedef struct packed {
		logic [31:0] digest_word;
		logic        word_last;
		logic        length_overflow;
	} shs_dig_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_HLOAD,
		ST_ROUND,
		ST_HADD,
		ST_OUT
	} shs_state_t;

	// what follows the compression of the current block
	typedef enum logic [1:0] {
		NXT_IDLE,
		NXT_PAD1,
		NXT_PAD2,
		NXT_OUT
	} shs_next_t;

	// controls from the sequencer to the round datapath
	typedef struct packed {
		logic       load_v;
		logic       sch_buf;
		logic       sch_gen;
		logic       round;
		logic       acc_shift;
		logic [5:0] rnd;
	} shs_core_ctl_t;

	localparam logic [60:0] TOTAL_MAX = '1;
	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [5:0]  LEN_POS   = 6'd56;

	localparam word_t HASH_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// File: rtl/core/sha256_stream_hasher.sv
// SHA-256 stream hasher. Message bytes come in one per request on the msg channel; a
// request with last set (with or without a byte) closes the message, and the eight
// big-endian digest words leave on the dig channel, first word first, after which
// the hasher starts over from the initial hash values. Bytes are taken one per cycle,
// while msg_stall is low, until the 64-byte block buffer is full; each full block then
// holds msg_stall high through the hash-memory reads into the working variables, the
// 64 rounds and the read-add-write back. Closing a message costs a padding pass over
// the sixteen buffer words and one compression, or two passes and two compressions
// when the 0x80 marker lands at byte 56 or later of its block, then each digest word
// goes through the hash-memory read port and the output register; the next word is
// read only after dig_stall lets the last one go. A byte beyond 2^61-1 total bytes is
// dropped and sets length_overflow on every word of that digest.
module sha256_stream_hasher import shs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     msg_valid,
	output logic     msg_stall,
	input  shs_msg_t msg,
	output logic     dig_valid,
	input  logic     dig_stall,
	output shs_dig_t dig
);

	shs_state_t    state_q, state_d;
	shs_next_t     nxt_q, nxt_d;
	logic [5:0]    cnt_q, cnt_d;
	logic [5:0]    fill_q;
	logic [60:0]   total_q;
	logic          ovf_q;
	logic          pad_mark_q, pad_mark_d;
	logic          rd_pend_q;
	logic          out_vld_q;
	shs_dig_t      dig_q;

	logic          msg_acc, dig_acc;
	logic          byte_take, byte_drop, blk_full, pad_len;
	logic [63:0]   bit_len;
	word_t         pad_data;
	logic [3:0]    pad_be;

	logic          buf_we, buf_re;
	logic [3:0]    buf_waddr, buf_raddr, buf_wbe;
	word_t         buf_wdata, buf_rdata;
	logic          hash_we, hash_re, hash_clr;
	logic [2:0]    hash_waddr, hash_raddr;
	word_t         hash_rdata, acc_sum;
	logic          out_issue, out_done;
	shs_core_ctl_t ctl;

	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_acc   = out_vld_q && !dig_stall;
	assign byte_take = msg_acc && msg.byte_valid && (total_q != TOTAL_MAX);
	assign byte_drop = msg_acc && msg.byte_valid && (total_q == TOTAL_MAX);
	assign blk_full  = byte_take && (fill_q == 6'd63);
	assign bit_len   = {total_q, 3'b000};
	assign pad_len   = !pad_mark_q || (fill_q < LEN_POS);
	assign msg_stall = (state_q != ST_IDLE);

	// padding word for buffer word cnt_q: keep, marker, zero or length byte
	always_comb begin
		logic [5:0] b;
		b        = '0;
		pad_data = '0;
		pad_be   = '0;
		for (int j = 0; j < 4; j++) begin
			b = {cnt_q[3:0], 2'(j)};
			if (pad_mark_q && (b == fill_q)) begin
				pad_data[8*(3-j) +: 8] = PAD_MARK;
				pad_be[3-j]            = 1'b1;
			end else if (pad_mark_q && (b < fill_q)) begin
				pad_be[3-j] = 1'b0;
			end else if (pad_len && (b >= LEN_POS)) begin
				pad_data[8*(3-j) +: 8] = bit_len[{~b[2:0], 3'b000} +: 8];
				pad_be[3-j]            = 1'b1;
			end else begin
				pad_be[3-j] = 1'b1;
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			nxt_q      <= NXT_IDLE;
			cnt_q      <= '0;
			pad_mark_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			nxt_q      <= nxt_d;
			cnt_q      <= cnt_d;
			pad_mark_q <= pad_mark_d;
		end
	end

	// sequencer next state and memory controls
	always_comb begin
		state_d    = state_q;
		nxt_d      = nxt_q;
		cnt_d      = cnt_q;
		pad_mark_d = pad_mark_q;
		ctl        = '0;
		buf_we     = 1'b0;
		buf_waddr  = fill_q[5:2];
		buf_wbe    = 4'b1000 >> fill_q[1:0];
		buf_wdata  = {4{msg.data_byte}};
		buf_re     = 1'b0;
		buf_raddr  = '0;
		hash_re    = 1'b0;
		hash_raddr = cnt_q[2:0];
		hash_we    = 1'b0;
		hash_waddr = cnt_q[2:0] - 3'd1;
		hash_clr   = 1'b0;
		out_issue  = 1'b0;
		out_done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				buf_we = byte_take;
				if (blk_full) begin
					state_d = ST_HLOAD;
					cnt_d   = '0;
					nxt_d   = msg.last ? NXT_PAD1 : NXT_IDLE;
				end else if (msg_acc && msg.last) begin
					state_d    = ST_PAD;
					cnt_d      = '0;
					pad_mark_d = 1'b1;
				end
			end
			ST_PAD: begin
				buf_we    = 1'b1;
				buf_waddr = cnt_q[3:0];
				buf_wbe   = pad_be;
				buf_wdata = pad_data;
				if (cnt_q == 6'd15) begin
					state_d = ST_HLOAD;
					cnt_d   = '0;
					nxt_d   = pad_len ? NXT_OUT : NXT_PAD2;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_HLOAD: begin
				hash_re    = (cnt_q < 6'd8);
				ctl.load_v = (cnt_q != 6'd0);
				if (cnt_q == 6'd7) begin
					buf_re    = 1'b1;
					buf_raddr = 4'd0;
				end
				if (cnt_q == 6'd8) begin
					buf_re      = 1'b1;
					buf_raddr   = 4'd1;
					ctl.sch_buf = 1'b1;
					state_d     = ST_ROUND;
					cnt_d       = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_ROUND: begin
				ctl.round = 1'b1;
				ctl.rnd   = cnt_q;
				if (cnt_q <= 6'd13) begin
					buf_re    = 1'b1;
					buf_raddr = cnt_q[3:0] + 4'd2;
				end
				if (cnt_q <= 6'd14) begin
					ctl.sch_buf = 1'b1;
				end else begin
					ctl.sch_gen = 1'b1;
				end
				if (cnt_q == 6'd63) begin
					state_d = ST_HADD;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_HADD: begin
				// read of word k overlaps write of word k-1, never the same entry
				hash_re       = (cnt_q < 6'd8);
				hash_we       = (cnt_q != 6'd0);
				ctl.acc_shift = (cnt_q != 6'd0);
				if (cnt_q == 6'd8) begin
					cnt_d = '0;
					unique case (nxt_q)
						NXT_IDLE: state_d = ST_IDLE;
						NXT_PAD1: begin
							state_d    = ST_PAD;
							pad_mark_d = 1'b1;
						end
						NXT_PAD2: begin
							state_d    = ST_PAD;
							pad_mark_d = 1'b0;
						end
						NXT_OUT:  state_d = ST_OUT;
						default:  state_d = ST_IDLE;
					endcase
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			ST_OUT: begin
				if (!rd_pend_q && !out_vld_q) begin
					hash_re   = 1'b1;
					out_issue = 1'b1;
				end
				if (rd_pend_q) begin
					if (cnt_q == 6'd7) begin
						state_d  = ST_IDLE;
						cnt_d    = '0;
						hash_clr = 1'b1;
						out_done = 1'b1;
					end else begin
						cnt_d = cnt_q + 6'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// fill count, byte total and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (out_done) begin
			fill_q  <= '0;
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (byte_take) begin
				fill_q  <= fill_q + 6'd1;
				total_q <= total_q + 61'd1;
			end
			if (byte_drop) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_pend_q <= out_issue;
			if (rd_pend_q) begin
				out_vld_q <= 1'b1;
			end else if (dig_acc) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			dig_q.digest_word     <= hash_rdata;
			dig_q.word_last       <= (cnt_q == 6'd7);
			dig_q.length_overflow <= ovf_q;
		end
	end

	assign dig_valid = out_vld_q;
	assign dig       = dig_q;

	shs_buf u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wbe   (buf_wbe),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	shs_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (hash_clr),
		.we     (hash_we),
		.waddr  (hash_waddr),
		.wdata  (acc_sum),
		.re     (hash_re),
		.raddr  (hash_raddr),
		.rdata  (hash_rdata)
	);

	shs_core u_core (
		.clk        (clk),
		.ctl        (ctl),
		.buf_rdata  (buf_rdata),
		.hash_rdata (hash_rdata),
		.acc_sum    (acc_sum)
	);

	// a captured digest word never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_vld_q)
		else $error("digest word captured over a pending word");

	// an end marker always starts finishing the message
	a_last_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_acc && msg.last) |=> (state_q == ST_PAD || state_q == ST_HLOAD))
		else $error("end marker did not start padding or compression");

	// the last block of a message leads straight to digest output
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HADD && cnt_q == 6'd8 && nxt_q == NXT_OUT) |=> state_q == ST_OUT)
		else $error("digest output did not follow the final compression");

	// a byte past the length limit leaves the total unchanged and flags overflow
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_drop && !out_done) |=> ($stable(total_q) && ovf_q))
		else $error("byte beyond the length limit was counted");

endmodule

// File: rtl/core/shs_buf.sv
module shs_buf import shs_pkg::*; (
	input  logic       clk,
	input  logic       we,
	input  logic [3:0] waddr,
	input  logic [3:0] wbe,
	input  word_t      wdata,
	input  logic       re,
	input  logic [3:0] raddr,
	output word_t      rdata
);

	word_t mem [16];
	word_t rdata_q;

	// byte-lane write, lane 3 holds the first byte of the word
	always_ff @(posedge clk) begin
		if (we) begin
			for (int j = 0; j < 4; j++) begin
				if (wbe[j]) begin
					mem[waddr][8*j +: 8] <= wdata[8*j +: 8];
				end
			end
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/shs_hash.sv
module shs_hash import shs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       we,
	input  logic [2:0] waddr,
	input  word_t      wdata,
	input  logic       re,
	input  logic [2:0] raddr,
	output word_t      rdata
);

	word_t      mem [8];
	logic [7:0] vld_q;
	word_t      rdata_q;

	// entry valid bits, an invalid entry reads as the initial hash value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= vld_q[raddr] ? mem[raddr] : HASH_IV[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/shs_core.sv
module shs_core import shs_pkg::*; (
	input  logic          clk,
	input  shs_core_ctl_t ctl,
	input  word_t         buf_rdata,
	input  word_t         hash_rdata,
	output word_t         acc_sum
);

	word_t v_q   [8];
	word_t sch_q [16];

	word_t ep0, ep1, ch, mj, t1, t2, sg0, sg1, w_new;

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// round function, sch_q[15] holds the schedule word of this round
	always_comb begin
		ep1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + ep1 + ch + ROUND_K[ctl.rnd] + sch_q[15];
		ep0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2  = ep0 + mj;
	end

	// next schedule word from the sixteen-word window
	always_comb begin
		sg0   = rotr(sch_q[1], 7) ^ rotr(sch_q[1], 18) ^ (sch_q[1] >> 3);
		sg1   = rotr(sch_q[14], 17) ^ rotr(sch_q[14], 19) ^ (sch_q[14] >> 10);
		w_new = sch_q[0] + sg0 + sch_q[9] + sg1;
	end

	// working variables: load from hash memory, rounds, drain for the final add
	always_ff @(posedge clk) begin
		if (ctl.load_v) begin
			for (int k = 0; k < 7; k++) begin
				v_q[k] <= v_q[k+1];
			end
			v_q[7] <= hash_rdata;
		end else if (ctl.acc_shift) begin
			for (int k = 0; k < 7; k++) begin
				v_q[k] <= v_q[k+1];
			end
			v_q[7] <= v_q[0];
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// schedule window shift
	always_ff @(posedge clk) begin
		if (ctl.sch_buf || ctl.sch_gen) begin
			for (int k = 0; k < 15; k++) begin
				sch_q[k] <= sch_q[k+1];
			end
			sch_q[15] <= ctl.sch_buf ? buf_rdata : w_new;
		end
	end

	assign acc_sum = hash_rdata + v_q[0];

endmodule
